@@ hdl/log_spaced_table_interpolator_core_macros.svh @@
// ----------------------------------------------------------------------------
// Log-spaced table interpolator assertion macros
// Shared concurrent check templates, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LOG_SPACED_TABLE_INTERPOLATOR_CORE_MACROS_SVH
`define LOG_SPACED_TABLE_INTERPOLATOR_CORE_MACROS_SVH

// same-cycle implication
`define LSTI_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LSTI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/lsti_pkg.sv @@
// ----------------------------------------------------------------------------
// lsti_pkg
// Types, constants and helpers of the log-spaced table interpolator.
// ----------------------------------------------------------------------------
package lsti_pkg;

    localparam int VALUE_W        = 32;
    localparam int SAMPLE_W       = 32;
    localparam int SLOT_W         = 5;
    localparam int EXP_W          = 8;
    localparam int COUNT_W        = 6;
    localparam int S_TDATA_W      = 72;
    localparam int EXP_FIELD_W    = 8;
    localparam int MANT_W         = 23;
    localparam int F_W            = 24;
    localparam int COEF_W         = 26;
    localparam int MUL_W          = 48;
    localparam int PROD_W         = 58;
    localparam int Q_FRAC         = 23;
    localparam int IDX_CALC_W     = 11;
    localparam int N_W            = 10;
    localparam int SLOT_CMP_W     = 9;
    localparam int TABLE_DEPTH_DEF = 32;

    localparam logic [EXP_FIELD_W-1:0] EXP_FIELD_MAX = 8'hFF;
    localparam logic signed [IDX_CALC_W-1:0] EXP_BIAS_M1 = 11'sd126;
    localparam logic signed [MANT_W+1:0] MANT_ONE_M1 = 25'sd8388607;

    localparam logic signed [COEF_W-1:0] COEF_P1 = 26'sd12626113;
    localparam logic signed [COEF_W-1:0] COEF_P2 = -26'sd6313057;
    localparam logic signed [COEF_W-1:0] COEF_P3 = 26'sd4208704;

    localparam logic signed [PROD_W-1:0] RND_HALF = 58'sd4194304;
    localparam logic signed [PROD_W-1:0] S_MAX    = 58'sd8388607;
    localparam logic signed [PROD_W-1:0] S_MIN    = -58'sd8388608;
    localparam logic signed [PROD_W-1:0] RES_MAX  = 58'sd2147483647;
    localparam logic signed [PROD_W-1:0] RES_MIN  = -58'sd2147483648;

    localparam logic signed [EXP_W-1:0] LOWEST_EXP_RST  = 8'sd0;
    localparam logic [COUNT_W-1:0]      ENTRY_COUNT_RST = 6'd32;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_EVAL  = 1'b1
    } op_t;

    typedef enum logic {
        CFG_LOWEST_EXP  = 1'b0,
        CFG_ENTRY_COUNT = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_WRITE   = 2'd1,
        STATUS_CLAMP   = 2'd2,
        STATUS_INVALID = 2'd3
    } status_t;

    typedef struct packed {
        status_t                    status;
        logic signed [F_W-1:0]      f;
        logic signed [VALUE_W-1:0]  hi;
        logic signed [VALUE_W-1:0]  lo;
    } front_t;

    typedef struct packed {
        status_t                    status;
        logic signed [F_W-1:0]      s;
        logic signed [VALUE_W-1:0]  hi;
        logic signed [VALUE_W:0]    diff;
    } poly_t;

    // round to nearest (ties up) and drop Q_FRAC fraction bits
    function automatic logic signed [PROD_W-1:0] rnd_q23(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] t;
        t = v + RND_HALF;
        return t >>> Q_FRAC;
    endfunction

endpackage

@@ hdl/lsti_front.sv @@
// ----------------------------------------------------------------------------
// lsti_front
// Item decode, index clamp, mantissa offset and sample table (stage 1).
// ----------------------------------------------------------------------------
module lsti_front #(
    parameter int TABLE_DEPTH = lsti_pkg::TABLE_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                op,
    input  logic [lsti_pkg::SLOT_W-1:0]         entry_index,
    input  logic signed [lsti_pkg::VALUE_W-1:0] entry_value,
    input  logic [lsti_pkg::SAMPLE_W-1:0]       sample_bits,
    input  logic signed [lsti_pkg::EXP_W-1:0]   lowest_exponent,
    input  logic [lsti_pkg::COUNT_W-1:0]        entry_count,
    output logic                                out_valid,
    input  logic                                out_ready,
    output lsti_pkg::front_t                    out_data
);

    localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW     = lsti_pkg::IDX_CALC_W;
    localparam int NW     = lsti_pkg::N_W;
    localparam int SW     = lsti_pkg::SLOT_CMP_W;
    localparam int FW     = lsti_pkg::F_W;
    localparam int MW     = lsti_pkg::MANT_W;
    localparam int EW     = lsti_pkg::EXP_FIELD_W;
    localparam int VW     = lsti_pkg::VALUE_W;

    logic signed [VW-1:0] table_mem [TABLE_DEPTH];
    logic signed [VW-1:0] hi_reg;
    logic signed [VW-1:0] lo_reg;

    logic                 valid_reg;
    lsti_pkg::status_t    status_reg;
    lsti_pkg::status_t    status_next;
    logic signed [FW-1:0] f_reg;
    logic signed [FW-1:0] f_next;

    logic                 en;
    logic [EW-1:0]        ef;
    logic [MW-1:0]        mant;
    logic                 bad_arg;
    logic [NW-1:0]        ec_ext;
    logic [NW-1:0]        n_cl;
    logic signed [CW-1:0] n_m1;
    logic signed [CW-1:0] i_raw;
    logic signed [CW-1:0] i_cl;
    logic                 clamped;
    logic [IDX_W-1:0]     rd_hi_addr;
    logic [IDX_W-1:0]     rd_lo_addr;
    logic signed [MW+1:0] f_full;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;

    assign en       = !valid_reg || out_ready;
    assign in_ready = en;

    always_comb
    begin
        ef      = sample_bits[MW+EW-1:MW];
        mant    = sample_bits[MW-1:0];
        bad_arg = sample_bits[lsti_pkg::SAMPLE_W-1] || (ef == '0)
                  || (ef == lsti_pkg::EXP_FIELD_MAX);

        ec_ext = NW'(entry_count);
        if (ec_ext < NW'(2))
            n_cl = NW'(2);
        else if (ec_ext > NW'(TABLE_DEPTH))
            n_cl = NW'(TABLE_DEPTH);
        else
            n_cl = ec_ext;
        n_m1 = $signed({1'b0, n_cl}) - CW'(1);

        i_raw   = $signed({3'b000, ef}) - lsti_pkg::EXP_BIAS_M1 - CW'(lowest_exponent);
        clamped = 1'b0;
        i_cl    = i_raw;
        if (i_raw < CW'(1))
        begin
            i_cl    = CW'(1);
            clamped = 1'b1;
        end
        else if (i_raw > n_m1)
        begin
            i_cl    = n_m1;
            clamped = 1'b1;
        end
        rd_hi_addr = i_cl[IDX_W-1:0];
        rd_lo_addr = rd_hi_addr - IDX_W'(1);

        // f = round((M - 2^23) / 2)
        f_full = $signed({2'b00, mant}) - lsti_pkg::MANT_ONE_M1;
        f_next = FW'(f_full >>> 1);

        if (lsti_pkg::op_t'(op) == lsti_pkg::OP_WRITE)
            status_next = lsti_pkg::STATUS_WRITE;
        else if (bad_arg)
            status_next = lsti_pkg::STATUS_INVALID;
        else if (clamped)
            status_next = lsti_pkg::STATUS_CLAMP;
        else
            status_next = lsti_pkg::STATUS_OK;

        wr_addr = IDX_W'(entry_index);
        wr_en   = in_valid && en && (lsti_pkg::op_t'(op) == lsti_pkg::OP_WRITE)
                  && (SW'(entry_index) < SW'(TABLE_DEPTH));
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            table_mem[wr_addr] <= entry_value;
        if (en)
        begin
            hi_reg <= table_mem[rd_hi_addr];
            lo_reg <= table_mem[rd_lo_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            status_reg <= status_next;
            f_reg      <= f_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = '{status: status_reg, f: f_reg, hi: hi_reg, lo: lo_reg};

endmodule

@@ hdl/lsti_poly.sv @@
// ----------------------------------------------------------------------------
// lsti_poly
// Cubic log2 mantissa approximation; stages 2-4 multiply, stage 5 saturates.
// ----------------------------------------------------------------------------
module lsti_poly (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  lsti_pkg::front_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output lsti_pkg::poly_t  out_data
);

    localparam int FW = lsti_pkg::F_W;
    localparam int CW = lsti_pkg::COEF_W;
    localparam int MW = lsti_pkg::MUL_W;
    localparam int PW = lsti_pkg::PROD_W;
    localparam int VW = lsti_pkg::VALUE_W;

    logic v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy2, rdy3, rdy4, rdy5;

    lsti_pkg::status_t    st2_reg, st3_reg, st4_reg, st5_reg;
    logic signed [FW-1:0] f2_reg, f3_reg;
    logic signed [VW-1:0] hi2_reg, hi3_reg, hi4_reg, hi5_reg;
    logic signed [VW:0]   diff2_reg, diff3_reg, diff4_reg, diff5_reg;
    logic signed [MW-1:0] m1_reg, m2_reg, m3_reg;
    logic signed [FW-1:0] s5_reg;

    logic signed [MW-1:0] m1_next, m2_next, m3_next;
    logic signed [VW:0]   diff_next;
    logic signed [PW-1:0] r1, r2, r3;
    logic signed [CW-1:0] t1, t2;
    logic signed [FW-1:0] s_next;

    assign rdy5     = !v5_reg || out_ready;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign in_ready = rdy2;

    always_comb
    begin
        m1_next   = MW'(lsti_pkg::COEF_P3) * MW'(in_data.f);
        diff_next = (VW+1)'(in_data.hi) - (VW+1)'(in_data.lo);

        r1      = lsti_pkg::rnd_q23(PW'(m1_reg));
        t1      = lsti_pkg::COEF_P2 + CW'(r1);
        m2_next = MW'(f2_reg) * MW'(t1);

        r2      = lsti_pkg::rnd_q23(PW'(m2_reg));
        t2      = lsti_pkg::COEF_P1 + CW'(r2);
        m3_next = MW'(f3_reg) * MW'(t2);

        r3 = lsti_pkg::rnd_q23(PW'(m3_reg));
        if (r3 > lsti_pkg::S_MAX)
            s_next = FW'(lsti_pkg::S_MAX);
        else if (r3 < lsti_pkg::S_MIN)
            s_next = FW'(lsti_pkg::S_MIN);
        else
            s_next = FW'(r3);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (rdy2)
                v2_reg <= in_valid;
            if (rdy3)
                v3_reg <= v2_reg;
            if (rdy4)
                v4_reg <= v3_reg;
            if (rdy5)
                v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            st2_reg   <= in_data.status;
            f2_reg    <= in_data.f;
            hi2_reg   <= in_data.hi;
            diff2_reg <= diff_next;
            m1_reg    <= m1_next;
        end
        if (rdy3)
        begin
            st3_reg   <= st2_reg;
            f3_reg    <= f2_reg;
            hi3_reg   <= hi2_reg;
            diff3_reg <= diff2_reg;
            m2_reg    <= m2_next;
        end
        if (rdy4)
        begin
            st4_reg   <= st3_reg;
            hi4_reg   <= hi3_reg;
            diff4_reg <= diff3_reg;
            m3_reg    <= m3_next;
        end
        if (rdy5)
        begin
            st5_reg   <= st4_reg;
            hi5_reg   <= hi4_reg;
            diff5_reg <= diff4_reg;
            s5_reg    <= s_next;
        end
    end

    assign out_valid = v5_reg;
    assign out_data  = '{status: st5_reg, s: s5_reg, hi: hi5_reg, diff: diff5_reg};

endmodule

@@ hdl/lsti_blend.sv @@
// ----------------------------------------------------------------------------
// lsti_blend
// Slope multiply, round, add, saturate; zero on write/invalid; out reg (6-7).
// ----------------------------------------------------------------------------
module lsti_blend (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  lsti_pkg::poly_t               in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [lsti_pkg::VALUE_W-1:0]  result,
    output lsti_pkg::status_t             status
);

    localparam int PW = lsti_pkg::PROD_W;
    localparam int VW = lsti_pkg::VALUE_W;

    logic v6_reg, v7_reg;
    logic rdy6, rdy7;

    lsti_pkg::status_t    st6_reg;
    logic signed [VW-1:0] hi6_reg;
    logic signed [PW-1:0] m4_reg;
    logic signed [PW-1:0] m4_next;
    logic signed [PW-1:0] sum;

    lsti_pkg::status_t    status_reg;
    logic [VW-1:0]        result_reg;
    logic [VW-1:0]        result_next;

    assign rdy7     = !v7_reg || out_ready;
    assign rdy6     = !v6_reg || rdy7;
    assign in_ready = rdy6;

    always_comb
    begin
        m4_next = PW'(in_data.s) * PW'(in_data.diff);
        sum     = PW'(hi6_reg) + lsti_pkg::rnd_q23(m4_reg);
        if ((st6_reg == lsti_pkg::STATUS_WRITE) || (st6_reg == lsti_pkg::STATUS_INVALID))
            result_next = '0;
        else if (sum > lsti_pkg::RES_MAX)
            result_next = VW'(lsti_pkg::RES_MAX);
        else if (sum < lsti_pkg::RES_MIN)
            result_next = VW'(lsti_pkg::RES_MIN);
        else
            result_next = VW'(sum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else
        begin
            if (rdy6)
                v6_reg <= in_valid;
            if (rdy7)
                v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy6)
        begin
            st6_reg <= in_data.status;
            hi6_reg <= in_data.hi;
            m4_reg  <= m4_next;
        end
        if (rdy7)
        begin
            status_reg <= st6_reg;
            result_reg <= result_next;
        end
    end

    assign out_valid = v7_reg;
    assign result    = result_reg;
    assign status    = status_reg;

endmodule

@@ hdl/log_spaced_table_interpolator_core.sv @@
// ----------------------------------------------------------------------------
// log_spaced_table_interpolator_core
// Interpolates a power-of-two spaced table, one item per cycle unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries items: tuser = op (0 write entry, 1 evaluate float32 sample).
//   A write stores entry_value at entry_index and returns result 0, status 1.
//   An evaluate returns T[i] + s*(T[i]-T[i-1]) with the log2 mantissa term s.
//   m_* returns one item per input item, in order: tdata = result,
//   tuser = status (0 ok, 1 write, 2 index clamped, 3 invalid argument).
//   cfg_* writes lowest_exponent (index 0) or entry_count (index 1); write
//   only while no item is in flight. cfg_ready is always high.
// Timing:
//   Seven register stages (decode and table read, four polynomial stages,
//   slope multiply, output register) carry each accepted item to its result.
//   One item per cycle is sustained while m_tready is high; a write is seen
//   by any evaluate accepted in the next cycle or later.
//   When m_tready is low each stage holds its item and bubbles close up;
//   s_tready drops only once all seven stages are full.
//   Reset empties the pipeline and sets lowest_exponent 0, entry_count 32;
//   table contents are not cleared and must be written before they are read.
// ----------------------------------------------------------------------------
`include "log_spaced_table_interpolator_core_macros.svh"

module log_spaced_table_interpolator_core #(
    parameter int TABLE_DEPTH = lsti_pkg::TABLE_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [4:0] entry_index, [36:5] entry_value, [68:37] sample_bits, [71:69] zero
    input  logic [lsti_pkg::S_TDATA_W-1:0]     s_tdata,
    // [0] op
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [31:0] result
    output logic [lsti_pkg::VALUE_W-1:0]       m_tdata,
    // [1:0] status
    output logic [1:0]                         m_tuser,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic                               cfg_index,
    input  logic [lsti_pkg::EXP_W-1:0]         cfg_data
);

    localparam int SLW = lsti_pkg::SLOT_W;
    localparam int VW  = lsti_pkg::VALUE_W;
    localparam int SMW = lsti_pkg::SAMPLE_W;

    logic signed [lsti_pkg::EXP_W-1:0] lowest_exponent_reg;
    logic signed [lsti_pkg::EXP_W-1:0] lowest_exponent_next;
    logic [lsti_pkg::COUNT_W-1:0]      entry_count_reg;
    logic [lsti_pkg::COUNT_W-1:0]      entry_count_next;

    logic               front_valid, front_ready;
    lsti_pkg::front_t   front_data;
    logic               poly_valid, poly_ready;
    lsti_pkg::poly_t    poly_data;
    lsti_pkg::status_t  out_status;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        lowest_exponent_next = lowest_exponent_reg;
        entry_count_next     = entry_count_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (lsti_pkg::cfg_reg_t'(cfg_index))
                lsti_pkg::CFG_LOWEST_EXP:  lowest_exponent_next = $signed(cfg_data);
                lsti_pkg::CFG_ENTRY_COUNT: entry_count_next = cfg_data[lsti_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lowest_exponent_reg <= lsti_pkg::LOWEST_EXP_RST;
            entry_count_reg     <= lsti_pkg::ENTRY_COUNT_RST;
        end
        else
        begin
            lowest_exponent_reg <= lowest_exponent_next;
            entry_count_reg     <= entry_count_next;
        end
    end

    lsti_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (s_tvalid),
        .in_ready        (s_tready),
        .op              (s_tuser),
        .entry_index     (s_tdata[SLW-1:0]),
        .entry_value     ($signed(s_tdata[SLW+VW-1:SLW])),
        .sample_bits     (s_tdata[SLW+VW+SMW-1:SLW+VW]),
        .lowest_exponent (lowest_exponent_reg),
        .entry_count     (entry_count_reg),
        .out_valid       (front_valid),
        .out_ready       (front_ready),
        .out_data        (front_data)
    );

    lsti_poly u_poly (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_data),
        .out_valid (poly_valid),
        .out_ready (poly_ready),
        .out_data  (poly_data)
    );

    lsti_blend u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (poly_valid),
        .in_ready  (poly_ready),
        .in_data   (poly_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .result    (m_tdata),
        .status    (out_status)
    );

    assign m_tuser = out_status;

    `LSTI_ASSERT_IMPLY(a_no_value_on_write_or_invalid,
        m_tvalid && (out_status == lsti_pkg::STATUS_WRITE
                     || out_status == lsti_pkg::STATUS_INVALID),
        m_tdata == '0, "write or invalid item carries a nonzero result")
    `LSTI_ASSERT_IMPLY(a_backpressure_only_when_full, !s_tready,
        m_tvalid && !m_tready, "input stalled while output not stalled")
    `LSTI_ASSERT_NEXT(a_accepted_item_enters, s_tvalid && s_tready,
        front_valid, "accepted item missing from first stage")

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the log-spaced table interpolator. The table is
// loaded first, then directed items cover the special float encodings,
// clamped indexes and extreme entries. Random phases follow under several
// lowest_exponent / entry_count settings. Every accepted item is run through
// a local fixed-point model and results are checked in order.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int     DRAIN_CYCLES  = 12;
    localparam int     STALL_LIMIT   = 2000;
    localparam int     PHASE_ITEMS   = 100;
    localparam int     RAND_PHASES   = 10;
    localparam int     SLOTS         = 32;
    localparam longint LOG2_C1       = 64'sd12626113;
    localparam longint LOG2_C2       = -64'sd6313057;
    localparam longint LOG2_C3       = 64'sd4208704;
    localparam longint Q23_UNIT      = 64'sd8388608;
    localparam longint VAL_MAX       = 64'sd2147483647;
    localparam longint VAL_MIN       = -64'sd2147483648;

    typedef struct {
        lsti_pkg::op_t op;
        logic [4:0]    slot;
        logic [31:0]   value;
        logic [31:0]   sample;
    } table_op_t;

    typedef struct {
        logic [31:0]       value;
        lsti_pkg::status_t status;
    } interp_out_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // [4:0] entry_index, [36:5] entry_value, [68:37] sample_bits, [71:69] zero
    logic [lsti_pkg::S_TDATA_W-1:0] s_tdata = '0;
    // [0] op
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // [31:0] result
    logic [lsti_pkg::VALUE_W-1:0] m_tdata;
    // [1:0] status
    logic [1:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [lsti_pkg::EXP_W-1:0] cfg_data = '0;

    // shadow state
    logic signed [31:0] shadow_table [SLOTS];
    logic signed [7:0]  cfg_lowest = 8'sd0;
    logic [5:0]         cfg_count = 6'd32;

    table_op_t   table_ops[$];
    interp_out_t interp_results[$];
    table_op_t   cur_op;
    interp_out_t want;
    int          ops_issued = 0;
    int          ops_accepted = 0;
    int          mismatch_count = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          rdy_mode = 0;
    int          rdy_left = 0;
    logic [7:0]  rdy_mask = 8'hFF;
    logic [2:0]  rdy_phase = 3'd0;
    int          idle_cycles = 0;

    log_spaced_table_interpolator_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // round to nearest, ties up, drop 23 fraction bits
    function automatic longint round_q23(input longint v);
        return (v + 64'sd4194304) >>> 23;
    endfunction

    function automatic interp_out_t apply_table_op(input table_op_t it);
        interp_out_t o;
        logic [7:0]  ef;
        longint      n, i, f, t1, t2, s, hi, lo, r;
        o.value = '0;
        if (it.op == lsti_pkg::OP_WRITE)
        begin
            shadow_table[it.slot] = it.value;
            o.status = lsti_pkg::STATUS_WRITE;
            return o;
        end
        ef = it.sample[30:23];
        if (it.sample[31] || ef == 8'h00 || ef == 8'hFF)
        begin
            o.status = lsti_pkg::STATUS_INVALID;
            return o;
        end
        n = longint'(cfg_count);
        if (n < 2)
            n = 2;
        if (n > SLOTS)
            n = SLOTS;
        i = longint'(ef) - 126 - longint'(cfg_lowest);
        o.status = lsti_pkg::STATUS_OK;
        if (i < 1)
        begin
            i = 1;
            o.status = lsti_pkg::STATUS_CLAMP;
        end
        else if (i > n - 1)
        begin
            i = n - 1;
            o.status = lsti_pkg::STATUS_CLAMP;
        end
        f  = (longint'(it.sample[22:0]) - Q23_UNIT + 1) >>> 1;
        t1 = LOG2_C2 + round_q23(LOG2_C3 * f);
        t2 = LOG2_C1 + round_q23(f * t1);
        s  = round_q23(f * t2);
        if (s < -Q23_UNIT)
            s = -Q23_UNIT;
        if (s > Q23_UNIT - 1)
            s = Q23_UNIT - 1;
        hi = longint'(shadow_table[i]);
        lo = longint'(shadow_table[i - 1]);
        r  = hi + round_q23(s * (hi - lo));
        if (r > VAL_MAX)
            r = VAL_MAX;
        if (r < VAL_MIN)
            r = VAL_MIN;
        o.value = r[31:0];
        return o;
    endfunction

    function automatic table_op_t mk_write(input logic [4:0] slot, input logic [31:0] val);
        table_op_t t;
        t.op     = lsti_pkg::OP_WRITE;
        t.slot   = slot;
        t.value  = val;
        t.sample = $urandom();
        return t;
    endfunction

    function automatic table_op_t mk_eval(input logic [31:0] bits);
        table_op_t t;
        t.op     = lsti_pkg::OP_EVAL;
        t.slot   = 5'($urandom_range(0, 31));
        t.value  = $urandom();
        t.sample = bits;
        return t;
    endfunction

    function automatic table_op_t rand_write_op();
        logic [31:0] v;
        case ($urandom_range(0, 3))
            0: v = $urandom();
            1: v = int'($urandom_range(0, 2097152)) - 1048576;
            2: v = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: v = int'($urandom_range(0, 268435456)) - 134217728;
        endcase
        return mk_write(5'($urandom_range(0, 31)), v);
    endfunction

    function automatic table_op_t rand_eval_op();
        logic [31:0] bits;
        int          r, n, i, ef;
        bits = $urandom();
        r    = $urandom_range(0, 99);
        n    = int'(cfg_count);
        if (n < 2)
            n = 2;
        if (n > SLOTS)
            n = SLOTS;
        if (r < 8)
        begin
            case ($urandom_range(0, 2))
                0: bits[31] = 1'b1;
                1: bits[30:23] = 8'h00;
                default: bits[30:23] = 8'hFF;
            endcase
        end
        else if (r >= 14)
        begin
            i  = $urandom_range(0, n);
            ef = 126 + int'(cfg_lowest) + i;
            if (ef < 1 || ef > 254)
                ef = $urandom_range(1, 254);
            bits[31]    = 1'b0;
            bits[30:23] = ef[7:0];
            case ($urandom_range(0, 9))
                0: bits[22:0] = '0;
                1: bits[22:0] = '1;
                default: ;
            endcase
        end
        return mk_eval(bits);
    endfunction

    task automatic push_op(input table_op_t t);
        table_ops.push_back(t);
        ops_issued++;
    endtask

    task automatic wait_drained();
        while (ops_accepted != ops_issued || interp_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(input lsti_pkg::cfg_reg_t idx, input logic [7:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == lsti_pkg::CFG_LOWEST_EXP)
            cfg_lowest = val;
        else
            cfg_count = val[5:0];
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // item driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                interp_results.push_back(apply_table_op(cur_op));
                ops_accepted++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (table_ops.size() > 0)
                begin
                    cur_op = table_ops.pop_front();
                    s_tdata  <= {3'b000, cur_op.sample, cur_op.value, cur_op.slot};
                    s_tuser  <= cur_op.op;
                    s_tvalid <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = ($urandom_range(0, 3) == 0) ? 150 : $urandom_range(1, 16);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // result monitor and ready pattern
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (interp_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: unexpected item result=%h status=%0d",
                                 $realtime, m_tdata, m_tuser);
                end
                else
                begin
                    want = interp_results.pop_front();
                    if (m_tdata !== want.value || m_tuser !== want.status)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("%0t: mismatch result exp=%h got=%h status exp=%0d got=%0d",
                                     $realtime, want.value, m_tdata, want.status, m_tuser);
                    end
                end
            end
            if (rdy_left == 0)
            begin
                rdy_mode = $urandom_range(0, 2);
                rdy_left = $urandom_range(20, 200);
                rdy_mask = 8'($urandom()) | 8'h01;
            end
            else
                rdy_left--;
            case (rdy_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 9) < 6);
                default:
                begin
                    m_tready <= rdy_mask[rdy_phase];
                    rdy_phase++;
                end
            endcase
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int          lowest_list [6];
        int          count_list [6];
        logic [31:0] fill;
        lowest_list = '{-126, 127, 0, -3, 5, -20};
        count_list  = '{2, 32, 0, 63, 1, 33};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // load every slot, extreme pairs at both ends of the table
        for (int k = 0; k < SLOTS; k++)
        begin
            if (k == 0 || k == 31)
                fill = 32'h7FFF_FFFF;
            else if (k == 1 || k == 30)
                fill = 32'h8000_0000;
            else
                fill = $urandom();
            push_op(mk_write(k[4:0], fill));
        end

        // special encodings, clamping, table ends, write then read back
        push_op(mk_eval(32'h0000_0000));
        push_op(mk_eval(32'h8000_0000));
        push_op(mk_eval(32'h0000_0001));
        push_op(mk_eval(32'h7F80_0000));
        push_op(mk_eval(32'h7FC0_0001));
        push_op(mk_eval(32'hBF80_0000));
        push_op(mk_eval(32'h0080_0000));
        push_op(mk_eval(32'h7F7F_FFFF));
        push_op(mk_eval(32'h3F80_0000));
        push_op(mk_eval(32'h3FFF_FFFF));
        push_op(mk_eval(32'h4F00_0000));
        push_op(mk_eval(32'h4E80_0000));
        push_op(mk_eval(32'h4EFF_FFFF));
        push_op(mk_eval(32'h3F00_0000));
        push_op(mk_write(5'd31, 32'h0000_0000));
        push_op(mk_eval(32'h4EC0_0000));
        push_op(mk_write(5'd0, 32'h8000_0000));
        push_op(mk_eval(32'h3FC0_0000));
        push_op(mk_eval(32'h4040_0000));
        wait_drained();

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            if (ph >= 1 && ph <= 6)
            begin
                write_cfg(lsti_pkg::CFG_LOWEST_EXP, 8'(lowest_list[ph - 1]));
                write_cfg(lsti_pkg::CFG_ENTRY_COUNT, 8'(count_list[ph - 1]));
            end
            else if (ph > 6)
            begin
                if ($urandom_range(0, 1))
                    write_cfg(lsti_pkg::CFG_LOWEST_EXP,
                              8'(int'($urandom_range(0, 60)) - 30));
                else
                    write_cfg(lsti_pkg::CFG_ENTRY_COUNT, 8'($urandom_range(2, 32)));
            end
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if ($urandom_range(0, 3) == 0)
                    push_op(rand_write_op());
                else
                    push_op(rand_eval_op());
            end
            wait_drained();
        end

        if (mismatch_count == 0 && interp_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
